>>> rtl/sct_pkg.sv
package sct_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int ARG_LIMIT     = 8;

    // position and length width (holds LINE_CAPACITY itself), store address width
    localparam int PW = $clog2(LINE_CAPACITY + 1);
    localparam int AW = $clog2(LINE_CAPACITY);
    // token index width (0 for the name, 1..ARG_LIMIT for arguments)
    localparam int KW = $clog2(ARG_LIMIT + 1);

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;

    typedef struct packed {
        logic clear;
        logic step;
        logic finish;
    } scan_ctl_t;

    typedef struct packed {
        logic [KW-1:0] args;
        logic          trunc;
    } scan_stat_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    endfunction

endpackage

>>> rtl/sct_scanner.sv
module sct_scanner (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sct_pkg::scan_ctl_t      ctl,
    input  logic [7:0]              ch,
    input  logic [sct_pkg::PW-1:0]  pos,
    input  logic [sct_pkg::KW-1:0]  rd_idx,
    output logic [sct_pkg::PW-1:0]  rd_lo,
    output logic [sct_pkg::PW-1:0]  rd_hi,
    output sct_pkg::scan_stat_t     stat
);
    import sct_pkg::*;

    logic          in_args_reg;
    logic          stop_reg;
    logic          has_reg;
    logic          tail_reg;
    logic [KW-1:0] k_reg;
    logic [PW-1:0] lo_reg;
    logic [PW-1:0] hi_reg;
    logic [PW-1:0] tok_lo_reg [0:ARG_LIMIT];
    logic [PW-1:0] tok_hi_reg [0:ARG_LIMIT];

    logic active;
    logic blank;
    logic colon_hit;
    logic comma_hit;
    logic fin;
    logic rec;

    always_comb
    begin
        active    = ctl.step && !stop_reg;
        blank     = is_blank(ch);
        colon_hit = active && !in_args_reg && (ch == CH_COLON);
        comma_hit = active && in_args_reg && (ch == CH_COMMA);
        fin       = ctl.finish && !stop_reg;
        rec       = colon_hit || comma_hit || fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_args_reg <= 1'b0;
            stop_reg    <= 1'b0;
            has_reg     <= 1'b0;
            tail_reg    <= 1'b0;
            k_reg       <= '0;
        end
        else if (ctl.clear)
        begin
            in_args_reg <= 1'b0;
            stop_reg    <= 1'b0;
            has_reg     <= 1'b0;
            tail_reg    <= 1'b0;
            k_reg       <= '0;
        end
        else if (colon_hit)
        begin
            in_args_reg <= 1'b1;
            has_reg     <= 1'b0;
            k_reg       <= KW'(1);
        end
        else if (comma_hit)
        begin
            tail_reg <= 1'b1;
            has_reg  <= 1'b0;
            // one more separator past the last kept argument drops the rest
            if (k_reg == KW'(ARG_LIMIT))
                stop_reg <= 1'b1;
            else
                k_reg <= k_reg + 1'b1;
        end
        else if (active && !blank)
        begin
            has_reg <= 1'b1;
            if (in_args_reg)
                tail_reg <= 1'b1;
        end
    end

    // trimmed bounds of the token in progress; both stay zero while it is empty
    always_ff @(posedge clk)
    begin
        if (ctl.clear || rec)
        begin
            lo_reg <= '0;
            hi_reg <= '0;
        end
        else if (active && !blank)
        begin
            if (!has_reg)
                lo_reg <= pos;
            hi_reg <= pos + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec)
        begin
            tok_lo_reg[k_reg] <= lo_reg;
            tok_hi_reg[k_reg] <= hi_reg;
        end
    end

    assign rd_lo = tok_lo_reg[rd_idx];
    assign rd_hi = tok_hi_reg[rd_idx];

    assign stat.args  = stop_reg ? KW'(ARG_LIMIT) :
                        ((in_args_reg && tail_reg) ? k_reg : '0);
    assign stat.trunc = stop_reg;

endmodule

>>> rtl/serial_command_tokenizer_core.sv
// channel  direction  handshake            payload
// rx       in         rx_valid/rx_ready    rx_byte
// tok      out        tok_valid/tok_ready  token_char, char_valid, token_index,
//                                          token_end, line_last, arg_count, truncated
//
// An ordinary byte is written into the line store at the fill count, or is dropped and
// sets the overflow flag once the store is full. A terminator on a non-empty line starts
// a scan of the store through its single read port; then each word out takes a table
// lookup, a store read or both, and a load, waiting while the output register is full.
// rx_ready is low from the terminator until the last word is loaded.
// Reset clears the fill count, overflow flag and handshake state; the store is not cleared.
module serial_command_tokenizer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       tok_valid,
    input  logic       tok_ready,
    output logic [7:0] token_char,
    output logic       char_valid,
    output logic [3:0] token_index,
    output logic       token_end,
    output logic       line_last,
    output logic [3:0] arg_count,
    output logic       truncated
);
    import sct_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN_RD = 3'd1;
    localparam logic [2:0] S_SCAN_PR = 3'd2;
    localparam logic [2:0] S_FIN     = 3'd3;
    localparam logic [2:0] S_TOK     = 3'd4;
    localparam logic [2:0] S_CH_RD   = 3'd5;
    localparam logic [2:0] S_LD      = 3'd6;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [PW-1:0] len_reg;
    logic          ovf_reg;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] cur_hi_reg;
    logic          empty_reg;
    logic [KW-1:0] tok_k_reg;

    logic [7:0]    mem [0:LINE_CAPACITY-1];
    logic [7:0]    rd_data_reg;
    logic          mem_we;
    logic          mem_re;

    logic          out_valid_reg;
    logic [7:0]    char_reg;
    logic          cvalid_reg;
    logic [3:0]    index_reg;
    logic          tend_reg;
    logic          last_reg;
    logic [3:0]    acount_reg;
    logic          trunc_reg;

    scan_ctl_t     scan_ctl;
    scan_stat_t    scan_stat;
    logic [PW-1:0] tab_lo;
    logic [PW-1:0] tab_hi;

    logic          rx_fire;
    logic          is_term;
    logic          slot_free;
    logic          load;
    logic          ld_end;
    logic          ld_last;

    always_comb
    begin
        rx_fire   = rx_valid && rx_ready;
        is_term   = (rx_byte == CH_LF) || (rx_byte == CH_CR);
        slot_free = !out_valid_reg || tok_ready;
        load      = (state_reg == S_LD) && slot_free;
        ld_end    = empty_reg || ((pos_reg + 1'b1) == cur_hi_reg);
        ld_last   = ld_end && (tok_k_reg == scan_stat.args);
        mem_we    = rx_fire && !is_term && (len_reg < PW'(LINE_CAPACITY));
        mem_re    = (state_reg == S_SCAN_RD) || (state_reg == S_CH_RD);
        scan_ctl.clear  = rx_fire && is_term && (len_reg != '0);
        scan_ctl.step   = (state_reg == S_SCAN_PR);
        scan_ctl.finish = (state_reg == S_FIN);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (scan_ctl.clear)
                    state_next = S_SCAN_RD;
            S_SCAN_RD:
                state_next = S_SCAN_PR;
            S_SCAN_PR:
                state_next = ((pos_reg + 1'b1) == len_reg) ? S_FIN : S_SCAN_RD;
            S_FIN:
                state_next = S_TOK;
            S_TOK:
                state_next = (tab_lo == tab_hi) ? S_LD : S_CH_RD;
            S_CH_RD:
                state_next = S_LD;
            S_LD:
                if (load)
                begin
                    if (!ld_end)
                        state_next = S_CH_RD;
                    else if (ld_last)
                        state_next = S_IDLE;
                    else
                        state_next = S_TOK;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mem_we)
                len_reg <= len_reg + 1'b1;
            else if (rx_fire && !is_term)
                ovf_reg <= 1'b1;
            // drop the line once its last word is loaded
            if (load && ld_last)
            begin
                len_reg <= '0;
                ovf_reg <= 1'b0;
            end
            if (load)
                out_valid_reg <= 1'b1;
            else if (tok_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[len_reg[AW-1:0]] <= rx_byte;
        if (mem_re)
            rd_data_reg <= mem[pos_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (scan_ctl.clear)
            pos_reg <= '0;
        else if (state_reg == S_SCAN_PR)
            pos_reg <= pos_reg + 1'b1;
        else if (state_reg == S_TOK)
            pos_reg <= tab_lo;
        else if (load && !ld_end)
            pos_reg <= pos_reg + 1'b1;

        if (state_reg == S_FIN)
            tok_k_reg <= '0;
        else if (load && ld_end && !ld_last)
            tok_k_reg <= tok_k_reg + 1'b1;

        if (state_reg == S_TOK)
        begin
            cur_hi_reg <= tab_hi;
            empty_reg  <= (tab_lo == tab_hi);
        end

        if (load)
        begin
            char_reg   <= empty_reg ? 8'd0 : rd_data_reg;
            cvalid_reg <= !empty_reg;
            index_reg  <= 4'(tok_k_reg);
            tend_reg   <= ld_end;
            last_reg   <= ld_last;
            acount_reg <= 4'(scan_stat.args);
            trunc_reg  <= scan_stat.trunc || ovf_reg;
        end
    end

    sct_scanner u_scanner (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (scan_ctl),
        .ch     (rd_data_reg),
        .pos    (pos_reg),
        .rd_idx (tok_k_reg),
        .rd_lo  (tab_lo),
        .rd_hi  (tab_hi),
        .stat   (scan_stat)
    );

    assign rx_ready    = (state_reg == S_IDLE);
    assign tok_valid   = out_valid_reg;
    assign token_char  = char_reg;
    assign char_valid  = cvalid_reg;
    assign token_index = index_reg;
    assign token_end   = tend_reg;
    assign line_last   = last_reg;
    assign arg_count   = acount_reg;
    assign truncated   = trunc_reg;

endmodule
